>>> sv/llex_pkg.sv
// Shared codes and types for the laser line exposure sequencer.
`default_nettype none

package llex_pkg;

    // Field widths fixed by the interface
    localparam int CMD_W   = 3;
    localparam int IDX_W   = 10;
    localparam int BYTE_W  = 8;
    localparam int MODE_W  = 2;
    localparam int DRIVE_W = 2;
    localparam int CFG_W   = 10;
    localparam int TICK_W  = 8;
    localparam int LOOP_W  = 8;

    // Commands
    localparam logic [CMD_W-1:0] CMD_WRITE_BYTE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET_MODE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LINE_SYNC  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_BYTE_SENT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TICK       = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ_LOOPS = 3'd5;

    // Modes
    localparam logic [MODE_W-1:0] MODE_OFF     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INIT    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_IDLE    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RUNNING = 2'd3;

    // Laser drive codes
    localparam logic [DRIVE_W-1:0] DRIVE_KEEP = 2'd0;
    localparam logic [DRIVE_W-1:0] DRIVE_OFF  = 2'd1;
    localparam logic [DRIVE_W-1:0] DRIVE_ON   = 2'd2;

    // Configuration register indexes
    localparam logic REG_START_ADDRESS = 1'b0;
    localparam logic REG_LINE_LENGTH   = 1'b1;

    // Status fields of one result beat (the byte itself comes from the line memory)
    typedef struct packed {
        logic                tx_valid;
        logic [DRIVE_W-1:0]  laser_drive;
        logic [MODE_W-1:0]   current_mode;
        logic                streaming;
        logic [LOOP_W-1:0]   loops_read;
    } llex_res_t;

endpackage

`default_nettype wire

>>> sv/llex_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module llex_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> sv/llex_ctrl.sv
// Sequencer state: mode, sync timer, loop count and line memory read pointer.
`default_nettype none

module llex_ctrl
    import llex_pkg::*;
#(
    parameter int LINE_DEPTH = 1024
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_fire,
    input  wire logic [CMD_W-1:0]              cmd,
    input  wire logic [IDX_W-1:0]              mem_index,
    input  wire logic [BYTE_W-1:0]             mem_data,
    input  wire logic [MODE_W-1:0]             mode_value,
    input  wire logic [$clog2(LINE_DEPTH)-1:0] start_ptr,
    input  wire logic [CFG_W-1:0]              line_length,
    output logic                               mem_we,
    output logic [$clog2(LINE_DEPTH)-1:0]      mem_waddr,
    output logic [BYTE_W-1:0]                  mem_wdata,
    output logic                               mem_re,
    output logic [$clog2(LINE_DEPTH)-1:0]      mem_raddr,
    output llex_res_t                          res
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam logic [AW-1:0] LAST_PTR = AW'(LINE_DEPTH - 1);

    logic [MODE_W-1:0] mode_reg,    mode_next;
    logic              blank_reg,   blank_next;
    logic [LOOP_W-1:0] loop_reg,    loop_next;
    logic              stream_reg,  stream_next;
    logic [AW-1:0]     rptr_reg,    rptr_next;
    logic              timer_reg,   timer_next;
    logic [TICK_W-1:0] tick_reg,    tick_next;
    logic [TICK_W-1:0] cmp_reg,     cmp_next;

    logic              idx_in_range;
    logic [AW-1:0]     fetch_addr;

    assign idx_in_range = (32'(mem_index) < 32'(LINE_DEPTH));

    always_comb begin
        mode_next   = mode_reg;
        blank_next  = blank_reg;
        loop_next   = loop_reg;
        stream_next = stream_reg;
        rptr_next   = rptr_reg;
        timer_next  = timer_reg;
        tick_next   = tick_reg;
        cmp_next    = cmp_reg;
        fetch_addr  = rptr_reg;

        mem_we      = 1'b0;
        mem_waddr   = AW'(mem_index);
        mem_wdata   = mem_data;
        mem_re      = 1'b0;

        res.tx_valid    = 1'b0;
        res.laser_drive = DRIVE_KEEP;
        res.loops_read  = '0;

        if (in_fire) begin
            unique case (cmd)
                CMD_WRITE_BYTE: begin
                    mem_we = idx_in_range;
                end
                CMD_SET_MODE: begin
                    unique case (mode_value)
                        MODE_OFF: begin
                            res.laser_drive = DRIVE_OFF;
                            stream_next     = 1'b0;
                            blank_next      = 1'b0;
                            mode_next       = MODE_OFF;
                        end
                        MODE_INIT: begin
                            stream_next = 1'b0;
                            blank_next  = 1'b0;
                            mode_next   = MODE_INIT;
                        end
                        MODE_IDLE: begin
                            if (mode_reg == MODE_INIT || mode_reg == MODE_RUNNING) begin
                                blank_next = 1'b1;
                                cmp_next   = TICK_W'(line_length >> 2);
                                mode_next  = MODE_IDLE;
                            end
                        end
                        default: begin
                            if (mode_reg == MODE_INIT || mode_reg == MODE_IDLE) begin
                                blank_next = 1'b0;
                                cmp_next   = TICK_W'(line_length >> 2);
                                mode_next  = MODE_RUNNING;
                            end
                        end
                    endcase
                end
                CMD_LINE_SYNC: begin
                    if (mode_reg == MODE_IDLE || mode_reg == MODE_RUNNING) begin
                        timer_next = 1'b1;
                        tick_next  = '0;
                        if (blank_reg) begin
                            res.laser_drive = DRIVE_OFF;
                        end else begin
                            loop_next    = loop_reg + 1'b1;
                            stream_next  = 1'b1;
                            fetch_addr   = start_ptr;
                            mem_re       = 1'b1;
                            res.tx_valid = 1'b1;
                        end
                    end
                end
                CMD_BYTE_SENT: begin
                    if (stream_reg) begin
                        mem_re       = 1'b1;
                        res.tx_valid = 1'b1;
                    end
                end
                CMD_TICK: begin
                    if (timer_reg) begin
                        if (tick_reg == cmp_reg) begin
                            stream_next     = 1'b0;
                            res.laser_drive = DRIVE_ON;
                            timer_next      = 1'b0;
                            tick_next       = '0;
                        end else begin
                            tick_next = tick_reg + 1'b1;
                        end
                    end
                end
                CMD_READ_LOOPS: begin
                    res.loops_read = loop_reg;
                    loop_next      = '0;
                end
                default: begin
                end
            endcase
        end

        // advance the pointer past the byte just fetched, wrapping at the end of the line memory
        if (mem_re) begin
            rptr_next = (fetch_addr == LAST_PTR) ? '0 : fetch_addr + 1'b1;
        end

        res.current_mode = mode_next;
        res.streaming    = stream_next;
    end

    assign mem_raddr = fetch_addr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_OFF;
            blank_reg  <= 1'b0;
            loop_reg   <= '0;
            stream_reg <= 1'b0;
            rptr_reg   <= '0;
            timer_reg  <= 1'b0;
            tick_reg   <= '0;
            cmp_reg    <= '0;
        end else begin
            mode_reg   <= mode_next;
            blank_reg  <= blank_next;
            loop_reg   <= loop_next;
            stream_reg <= stream_next;
            rptr_reg   <= rptr_next;
            timer_reg  <= timer_next;
            tick_reg   <= tick_next;
            cmp_reg    <= cmp_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/laser_line_exposure_sequencer_unit.sv
// Top level of the laser line exposure sequencer.
//
// Takes one command beat per cycle unless stalled and returns exactly one result beat
// per command, in the cycle after acceptance. Line bytes live in a LINE_DEPTH x 8
// synchronous RAM: a write-byte command writes it, a line sync (running mode) or a
// byte-sent command reads it, and the registered read data lands in the output stage
// alongside the status fields. The mode, sync timer, loop count and read pointer sit
// in flip-flops in the control unit and are updated in the cycle of acceptance, so
// back-to-back syncs, ticks and byte-sent beats need no extra states; throughput is
// one beat per clock while m_ready is high, set by the single RAM read port and the
// one-deep output register. s_ready drops only while a result beat is held by m_ready
// low. Configuration writes (start address, line length) are registered; the start
// address is folded into the line memory range when written. Line memory entries hold
// no reset value and must be written before a line is streamed through them.
`default_nettype none

module laser_line_exposure_sequencer_unit
    import llex_pkg::*;
#(
    parameter int LINE_DEPTH = 1024
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // configuration
    input  wire logic                cfg_we,
    input  wire logic                cfg_index,
    input  wire logic [CFG_W-1:0]    cfg_wdata,
    // command channel
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [CMD_W-1:0]    s_cmd,
    input  wire logic [IDX_W-1:0]    s_mem_index,
    input  wire logic [BYTE_W-1:0]   s_mem_data,
    input  wire logic [MODE_W-1:0]   s_mode_value,
    // result channel
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [BYTE_W-1:0]        m_tx_byte,
    output logic                     m_tx_valid,
    output logic [DRIVE_W-1:0]       m_laser_drive,
    output logic [MODE_W-1:0]        m_current_mode,
    output logic                     m_streaming,
    output logic [LOOP_W-1:0]        m_loops_read
);

    localparam int AW = $clog2(LINE_DEPTH);
    // Largest number of whole depths that a 10-bit start address can reach
    localparam int MAXQ = ((1 << CFG_W) - 1) / LINE_DEPTH;
    localparam int RW = CFG_W + AW + 1;

    logic [AW-1:0]    start_ptr_reg,  start_ptr_next;
    logic [CFG_W-1:0] line_len_reg,   line_len_next;
    logic             m_valid_reg,    m_valid_next;
    llex_res_t        res_reg,        res_next;

    logic             s_fire;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;
    logic [BYTE_W-1:0] mem_rdata;
    logic [RW-1:0]    start_fold;

    // Hand over a new beat whenever the output stage is empty or being drained
    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    // Fold the start address into the memory range: pick the largest multiple of
    // the depth not above it. Each candidate compares against a constant.
    always_comb begin
        start_fold = RW'(cfg_wdata);
        for (int k = 1; k <= MAXQ; k++) begin
            if (RW'(cfg_wdata) >= RW'(k * LINE_DEPTH)) begin
                start_fold = RW'(cfg_wdata) - RW'(k * LINE_DEPTH);
            end
        end
    end

    always_comb begin
        start_ptr_next = start_ptr_reg;
        line_len_next  = line_len_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_START_ADDRESS: start_ptr_next = AW'(start_fold);
                REG_LINE_LENGTH:   line_len_next  = cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    llex_ctrl #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_fire     (s_fire),
        .cmd         (s_cmd),
        .mem_index   (s_mem_index),
        .mem_data    (s_mem_data),
        .mode_value  (s_mode_value),
        .start_ptr   (start_ptr_reg),
        .line_length (line_len_reg),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .res         (res_next)
    );

    // Read data only moves on an accepted fetch, so it holds with a stalled beat
    llex_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (LINE_DEPTH)
    ) u_line_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Output stage: load on accept, drop once taken, hold while stalled
    always_comb begin
        if (s_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_ptr_reg <= '0;
            line_len_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            start_ptr_reg <= start_ptr_next;
            line_len_reg  <= line_len_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            res_reg <= res_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_tx_valid     = res_reg.tx_valid;
    assign m_tx_byte      = res_reg.tx_valid ? mem_rdata : '0;
    assign m_laser_drive  = res_reg.laser_drive;
    assign m_current_mode = res_reg.current_mode;
    assign m_streaming    = res_reg.streaming;
    assign m_loops_read   = res_reg.loops_read;

endmodule

`default_nettype wire

>>> sv/llex_checker.sv
// Port-level checks for the laser line exposure sequencer, bound to the top level.
`default_nettype none

module llex_checker
    import llex_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire logic [BYTE_W-1:0]   m_tx_byte,
    input wire logic                m_tx_valid,
    input wire logic [DRIVE_W-1:0]  m_laser_drive,
    input wire logic [MODE_W-1:0]   m_current_mode,
    input wire logic                m_streaming
);

    // A stalled result beat stays valid and holds its byte and laser drive
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_tx_byte) && $stable(m_laser_drive))
        else $error("result beat changed while stalled");

    // A beat without a byte carries a zero byte
    a_idle_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_tx_valid |-> m_tx_byte == '0)
        else $error("tx_byte non-zero without tx_valid");

    // A byte only goes out while streaming in idle or running mode
    a_byte_streams: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_tx_valid |-> m_streaming &&
            (m_current_mode == MODE_IDLE || m_current_mode == MODE_RUNNING))
        else $error("byte sent outside a stream");

    // Forcing the laser on ends the stream, and a beat that forces it on carries no byte
    a_drive_on: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_laser_drive == DRIVE_ON |-> !m_streaming && !m_tx_valid)
        else $error("laser forced on while streaming");

    // Drive code stays within its defined codes
    a_drive_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_laser_drive == DRIVE_KEEP || m_laser_drive == DRIVE_OFF ||
            m_laser_drive == DRIVE_ON)
        else $error("undefined laser drive code");

endmodule

bind laser_line_exposure_sequencer_unit llex_checker u_llex_checker (.*);

`default_nettype wire
